@@ rtl/kmb_pkg.sv @@
// Package for the keyframe morph blend block: widths, types and controller states.
// No dependencies.
package kmb_pkg;
   localparam int MaxKeyframes = 8;
   localparam int AttrWidth    = 32;
   localparam int NumLanes     = 8;
   localparam int NumWeights   = 8;
   localparam int AccBits      = 52;
   localparam int SumBits      = 19;
   localparam int WeightBits   = 16;
   localparam int IdxBits      = 3;
   localparam int QuoBits      = 52;
   localparam int CntBits      = 6;

   typedef logic signed [AccBits-1:0] acc_type;

   typedef enum logic [2:0] {
      ST_ACCEPT,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_LANE_DONE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic take_item;
      logic div_start;
      logic div_step;
      logic lane_store;
      logic lane_next;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic last_item;
      logic div_last_step;
      logic last_lane;
      logic zero_sum;
   } status_type;
endpackage

@@ rtl/keyframe_morph_blend.sv @@
// Top level of the keyframe morph blend block.
// Depends on kmb_pkg, kmb_control and kmb_datapath.
//
// Blends one vertex over keyframe samples: each accepted word is one sample whose eight
// Q16.16 components are multiplied by the Q8.8 weight of its keyframe and added into
// eight 52-bit lanes, one multiply per lane, all lanes together; after a sample not
// marked last the next sample can be taken at once. On the last sample the sum of
// weights divides every lane in turn through one shared restoring divider producing
// one quotient bit a cycle: once the last mark is seen, each lane in turn is loaded
// into the divider, run through its quotient steps and stored; after the last lane
// the result word is shown. A zero weight sum gives zero fields and the error flag.
// Quotients round toward zero and saturate to 32 bits. The user must write weights
// through the csr port only while the block is idle; the block does not enforce this.
module keyframe_morph_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_keyframe_index,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_tex_u,
   input  logic [31:0] req_tex_v,
   input  logic [31:0] req_norm_x,
   input  logic [31:0] req_norm_y,
   input  logic [31:0] req_norm_z,
   input  logic        req_last_keyframe,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_pos_x,
   output logic [31:0] rsp_out_pos_y,
   output logic [31:0] rsp_out_pos_z,
   output logic [31:0] rsp_out_tex_u,
   output logic [31:0] rsp_out_tex_v,
   output logic [31:0] rsp_out_norm_x,
   output logic [31:0] rsp_out_norm_y,
   output logic [31:0] rsp_out_norm_z,
   output logic        rsp_zero_weight_error
);
   kmb_pkg::cmd_type                   cmd;
   kmb_pkg::status_type                status;
   logic [kmb_pkg::NumLanes-1:0][31:0] req_attr, rsp_attr;

   // pack the components into lanes
   assign req_attr = {req_norm_z, req_norm_y, req_norm_x, req_tex_v,
                      req_tex_u, req_pos_z, req_pos_y, req_pos_x};

   kmb_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd)
   );

   kmb_datapath u_datapath (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_keyframe_index(req_keyframe_index), .req_attr(req_attr),
      .req_last_keyframe(req_last_keyframe),
      .cmd(cmd), .status(status),
      .rsp_attr(rsp_attr), .rsp_error(rsp_zero_weight_error)
   );

   assign rsp_out_pos_x  = rsp_attr[0];
   assign rsp_out_pos_y  = rsp_attr[1];
   assign rsp_out_pos_z  = rsp_attr[2];
   assign rsp_out_tex_u  = rsp_attr[3];
   assign rsp_out_tex_v  = rsp_attr[4];
   assign rsp_out_norm_x = rsp_attr[5];
   assign rsp_out_norm_y = rsp_attr[6];
   assign rsp_out_norm_z = rsp_attr[7];
endmodule

@@ rtl/kmb_datapath.sv @@
// Datapath: weight registers, lane MAC, shared restoring divider and result registers.
// Depends on kmb_pkg.
module kmb_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [2:0]                         csr_index,
   input  logic [kmb_pkg::WeightBits-1:0]     csr_write_data,
   input  logic [kmb_pkg::IdxBits-1:0]        req_keyframe_index,
   input  logic [kmb_pkg::NumLanes-1:0][31:0] req_attr,
   input  logic                               req_last_keyframe,
   input  kmb_pkg::cmd_type                   cmd,
   output kmb_pkg::status_type                status,
   output logic [kmb_pkg::NumLanes-1:0][31:0] rsp_attr,
   output logic                               rsp_error
);
   logic signed [kmb_pkg::WeightBits-1:0] weight_ff [kmb_pkg::NumWeights];
   kmb_pkg::acc_type                      acc_ff [kmb_pkg::NumLanes];
   logic signed [kmb_pkg::SumBits-1:0]    sum_ff;
   logic                                  last_ff;
   logic [2:0]                            lane_ff;
   logic [kmb_pkg::CntBits-1:0]           step_ff;
   logic [kmb_pkg::QuoBits-1:0]           dividend_ff, quo_ff;
   logic [kmb_pkg::SumBits:0]             rem_ff;
   logic [kmb_pkg::SumBits-1:0]           divisor_ff;
   logic                                  neg_ff;
   logic [kmb_pkg::NumLanes-1:0][31:0]    res_ff;
   logic                                  err_ff;

   logic signed [kmb_pkg::WeightBits-1:0] w_sel;
   logic signed [kmb_pkg::SumBits-1:0]    sum_in;
   kmb_pkg::acc_type                      acc_abs;
   logic [kmb_pkg::SumBits:0]             rem_shift, rem_sub;
   logic signed [kmb_pkg::QuoBits:0]      q_signed;
   logic [31:0]                           q_sat;

   always_comb begin
      w_sel = weight_ff[req_keyframe_index];
      if ({1'b0, req_keyframe_index} >= (kmb_pkg::IdxBits+1)'(kmb_pkg::MaxKeyframes)) begin
         w_sel = '0;
      end
      sum_in = sum_ff + kmb_pkg::SumBits'(w_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kmb_pkg::NumWeights; i++) weight_ff[i] <= '0;
      end else if (csr_write_enable && {1'b0, csr_index} < 4'(kmb_pkg::NumWeights)) begin
         weight_ff[csr_index] <= csr_write_data;
      end
   end

   // one MAC per lane on each sample
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < kmb_pkg::NumLanes; i++) acc_ff[i] <= '0;
         sum_ff  <= '0;
         last_ff <= 1'b0;
      end else if (cmd.take_item) begin
         for (int i = 0; i < kmb_pkg::NumLanes; i++) begin
            acc_ff[i] <= acc_ff[i] + kmb_pkg::AccBits'(
               w_sel * $signed(req_attr[i][kmb_pkg::AttrWidth-1:0]));
         end
         sum_ff  <= sum_in;
         last_ff <= req_last_keyframe;
      end
   end

   assign acc_abs   = acc_ff[lane_ff][kmb_pkg::AccBits-1] ? -acc_ff[lane_ff] : acc_ff[lane_ff];
   assign rem_shift = {rem_ff[kmb_pkg::SumBits-1:0], dividend_ff[kmb_pkg::QuoBits-1]};
   assign rem_sub   = rem_shift - {1'b0, divisor_ff};

   // shared restoring divider, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dividend_ff <= kmb_pkg::QuoBits'(acc_abs);
         divisor_ff  <= sum_ff[kmb_pkg::SumBits-1] ? kmb_pkg::SumBits'(-sum_ff)
                                                   : kmb_pkg::SumBits'(sum_ff);
         neg_ff      <= acc_ff[lane_ff][kmb_pkg::AccBits-1] ^ sum_ff[kmb_pkg::SumBits-1];
         rem_ff      <= '0;
         quo_ff      <= '0;
         step_ff     <= '0;
      end else if (cmd.div_step) begin
         dividend_ff <= {dividend_ff[kmb_pkg::QuoBits-2:0], 1'b0};
         if (!rem_sub[kmb_pkg::SumBits]) begin
            rem_ff <= rem_sub;
            quo_ff <= {quo_ff[kmb_pkg::QuoBits-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            quo_ff <= {quo_ff[kmb_pkg::QuoBits-2:0], 1'b0};
         end
         step_ff <= step_ff + 1'b1;
      end
   end

   always_comb begin
      q_signed = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (q_signed > (kmb_pkg::QuoBits+1)'((64'sd1 <<< (kmb_pkg::AttrWidth-1)) - 1)) begin
         q_sat = 32'((64'sd1 <<< (kmb_pkg::AttrWidth-1)) - 1);
      end else if (q_signed < -(kmb_pkg::QuoBits+1)'(64'sd1 <<< (kmb_pkg::AttrWidth-1))) begin
         q_sat = 32'(-(64'sd1 <<< (kmb_pkg::AttrWidth-1)));
      end else begin
         q_sat = q_signed[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         lane_ff <= '0;
      end else if (cmd.lane_next) begin
         lane_ff <= lane_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lane_store) begin
         res_ff[lane_ff] <= status.zero_sum ? '0 : q_sat;
         err_ff          <= status.zero_sum;
      end
   end

   assign status.last_item     = last_ff;
   assign status.div_last_step = (step_ff == kmb_pkg::CntBits'(kmb_pkg::QuoBits-1));
   assign status.last_lane     = (lane_ff == 3'(kmb_pkg::NumLanes-1));
   assign status.zero_sum      = (sum_ff == '0);
   assign rsp_attr  = res_ff;
   assign rsp_error = err_ff;
endmodule

@@ rtl/kmb_control.sv @@
// Controller state machine sequencing accumulation, division and output.
// Depends on kmb_pkg.
module kmb_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  kmb_pkg::status_type status,
   output kmb_pkg::cmd_type    cmd
);
   kmb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmb_pkg::ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         kmb_pkg::ST_ACCEPT: begin
            req_ready     = 1'b1;
            cmd.take_item = req_valid;
            if (status.last_item) begin
               req_ready     = 1'b0;
               cmd.take_item = 1'b0;
               state_in      = kmb_pkg::ST_DIV_START;
            end
         end
         kmb_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = kmb_pkg::ST_DIV_RUN;
         end
         kmb_pkg::ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (status.div_last_step) state_in = kmb_pkg::ST_LANE_DONE;
         end
         kmb_pkg::ST_LANE_DONE: begin
            cmd.lane_store = 1'b1;
            cmd.lane_next  = 1'b1;
            state_in = status.last_lane ? kmb_pkg::ST_OUTPUT : kmb_pkg::ST_DIV_START;
         end
         kmb_pkg::ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.clear = 1'b1;
               state_in  = kmb_pkg::ST_ACCEPT;
            end
         end
         default: state_in = kmb_pkg::ST_ACCEPT;
      endcase
   end
endmodule

@@ rtl/kmb_checker.sv @@
// Port-level checker for the keyframe morph blend block, bound to the top level.
// Depends on keyframe_morph_blend ports only.
module kmb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_keyframe,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_pos_x,
   input logic        rsp_zero_weight_error
);
   // no new sample while a result word waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("sample taken during result");
   // a last sample closes input: req_ready is checked low just after it is taken
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_keyframe) |=> !req_ready)
      else $error("input open after last sample");
   // error result carries a zero pos_x field
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_weight_error) |-> rsp_out_pos_x == '0)
      else $error("nonzero field with error");
   // held result stays valid and its pos_x field stays stable
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_out_pos_x))
      else $error("result dropped");
endmodule

bind keyframe_morph_blend kmb_checker u_kmb_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_last_keyframe(req_last_keyframe), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_out_pos_x(rsp_out_pos_x), .rsp_zero_weight_error(rsp_zero_weight_error)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for keyframe_morph_blend: directed table, then random vertices.
// Depends on kmb_pkg and the keyframe_morph_blend RTL.
module testbench;
   localparam int Latency = 600;

   typedef struct packed {
      logic [2:0]  kf;
      logic [7:0][31:0] comp;
      logic        last;
   } sample_type;

   typedef struct packed {
      logic [7:0][31:0] comp;
      logic        zero_err;
   } vertex_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sample_type  req_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0][31:0] rsp_comp;
   logic        rsp_zero_weight_error;

   // Own copy of the block's state
   logic signed [15:0] blend_weights [8];
   logic [51:0]        lane_acc [8];
   logic [18:0]        weight_total;
   vertex_type         vertices_due [$];
   int                 mismatches = 0;
   bit                 hold_rsp = 1'b0;
   bit                 calm = 1'b0;

   always #1 clock = ~clock;

   keyframe_morph_blend i_dut (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .req_valid, .req_ready,
      .req_keyframe_index(req_word.kf),
      .req_pos_x(req_word.comp[0]), .req_pos_y(req_word.comp[1]),
      .req_pos_z(req_word.comp[2]), .req_tex_u(req_word.comp[3]),
      .req_tex_v(req_word.comp[4]), .req_norm_x(req_word.comp[5]),
      .req_norm_y(req_word.comp[6]), .req_norm_z(req_word.comp[7]),
      .req_last_keyframe(req_word.last),
      .rsp_valid, .rsp_ready,
      .rsp_out_pos_x(rsp_comp[0]), .rsp_out_pos_y(rsp_comp[1]),
      .rsp_out_pos_z(rsp_comp[2]), .rsp_out_tex_u(rsp_comp[3]),
      .rsp_out_tex_v(rsp_comp[4]), .rsp_out_norm_x(rsp_comp[5]),
      .rsp_out_norm_y(rsp_comp[6]), .rsp_out_norm_z(rsp_comp[7]),
      .rsp_zero_weight_error
   );

   // Fold one accepted sample in; queue the blended vertex on a last sample.
   task automatic blend_sample(input sample_type s);
      logic signed [63:0] w, q, den;
      logic signed [51:0] acc;
      vertex_type v;
      w = (s.kf < kmb_pkg::MaxKeyframes) ? 64'(blend_weights[s.kf]) : 64'sd0;
      for (int i = 0; i < 8; i++)
         lane_acc[i] = lane_acc[i] + 52'(w * $signed(s.comp[i]));
      weight_total = weight_total + 19'(w);
      if (!s.last) return;
      den = $signed(weight_total);
      v = '0;
      if (den == 0) begin
         v.zero_err = 1'b1;
      end else begin
         for (int i = 0; i < 8; i++) begin
            acc = $signed(lane_acc[i]);
            q = 64'(acc) / den;
            if (q > 64'sh7fffffff) q = 64'sh7fffffff;
            if (q < -64'sh80000000) q = -64'sh80000000;
            v.comp[i] = q[31:0];
         end
      end
      vertices_due = {vertices_due, v};
      for (int i = 0; i < 8; i++) lane_acc[i] = '0;
      weight_total = '0;
   endtask

   task automatic send_sample(input sample_type s);
      req_word  <= s;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      blend_sample(s);
      // Drop valid only when the next word will not follow straight away
      if (!calm && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic write_weight(input logic [2:0] idx, input logic [15:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      blend_weights[idx] = val;
      @(posedge clock);
   endtask

   // Wait for every vertex to drain, then let the divider settle.
   task automatic drain;
      req_valid <= 1'b0;
      while (vertices_due.size() != 0) @(posedge clock);
      repeat (Latency) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_attr();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(4))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($signed($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom());
      endcase
   endfunction

   // Receiver: random stalls, one long hold-off to back the block up.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (vertices_due.size() == 0) begin
            $display("%0t: unexpected vertex %h", $time, {rsp_comp, rsp_zero_weight_error});
            mismatches++;
         end else begin
            vertex_type e;
            e = vertices_due.pop_front();
            for (int i = 0; i < 8; i++)
               if (rsp_comp[i] !== e.comp[i]) begin
                  $display("%0t: lane %0d expected %h actual %h", $time, i, e.comp[i],
                           rsp_comp[i]);
                  mismatches++;
               end
            if (rsp_zero_weight_error !== e.zero_err) begin
               $display("%0t: error flag expected %b actual %b", $time, e.zero_err,
                        rsp_zero_weight_error);
               mismatches++;
            end
         end
      end
      rsp_ready <= !hold_rsp && (calm || $urandom_range(99) >= 31);
   end

   initial begin
      #5000000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      sample_type s;
      vertex_type v;
      typedef struct {
         sample_type s;
         bit         typed;
         vertex_type v;
      } row_type;
      row_type tbl [$];
      row_type r;

      for (int i = 0; i < 8; i++) begin
         blend_weights[i] = '0;
         lane_acc[i] = '0;
      end
      weight_total = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset every weight is zero: zero sum gives the error flag
      s = '0; s.comp = {8{32'h7fffffff}}; s.last = 1'b1;
      v = '0; v.zero_err = 1'b1;
      r = '{s, 1'b1, v};
      tbl = {tbl, r};
      foreach (tbl[k]) begin
         blend_sample(tbl[k].s);
         v = vertices_due.pop_back();
         if (v !== tbl[k].v) begin
            $display("%0t: table row %0d expected %h actual %h", $time, k, tbl[k].v, v);
            mismatches++;
         end
         vertices_due = {vertices_due, tbl[k].v};
         req_word <= tbl[k].s; req_valid <= 1'b1;
         do @(posedge clock); while (!req_ready);
      end
      tbl.delete();
      drain();

      // Unit weights, then extremes
      for (int i = 0; i < 8; i++) write_weight(3'(i), 16'h0100);
      s = '0; s.comp = {8{32'h00010000}}; s.last = 1'b1;
      v = '0; v.comp = {8{32'h00010000}};
      r = '{s, 1'b1, v};
      tbl = {tbl, r};
      s = '0; s.kf = 3'd7; s.comp = {8{32'h80000000}}; s.last = 1'b1;
      v = '0; v.comp = {8{32'h80000000}};
      r = '{s, 1'b1, v};
      tbl = {tbl, r};
      for (int k = 0; k < 8; k++) begin
         s = '0; s.kf = 3'(k);
         for (int i = 0; i < 8; i++) s.comp[i] = (i[0]) ? 32'h7fffffff : 32'h80000000;
         s.last = (k == 7);
         r = '{s, 1'b0, v};
         tbl = {tbl, r};
      end
      foreach (tbl[k]) begin
         if (tbl[k].typed) begin
            blend_sample(tbl[k].s);
            v = vertices_due.pop_back();
            if (v !== tbl[k].v) begin
               $display("%0t: table row %0d expected %h actual %h", $time, k, tbl[k].v, v);
               mismatches++;
            end
            vertices_due = {vertices_due, tbl[k].v};
            req_word <= tbl[k].s; req_valid <= 1'b1;
            do @(posedge clock); while (!req_ready);
         end else begin
            send_sample(tbl[k].s);
         end
      end
      drain();
      // Extreme weights: saturation and cancelling sums
      write_weight(3'd0, 16'h0001);
      write_weight(3'd1, 16'h7fff);
      write_weight(3'd2, 16'h8000);
      write_weight(3'd3, 16'h8001);
      for (int k = 0; k < 4; k++) begin
         s = '0; s.kf = 3'(k);
         for (int i = 0; i < 8; i++) s.comp[i] = pick_attr();
         s.last = (k == 0 || k == 3);
         send_sample(s);
      end
      drain();

      // Random vertices in phases, with fresh weights each phase
      for (int ph = 0; ph < 12; ph++) begin
         for (int i = 0; i < 8; i++) write_weight(3'(i), pick_weight());
         calm = (ph == 5);
         if (ph == 3)
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (3000) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         for (int n = 0; n < 70; n++) begin
            s = '0;
            s.kf   = 3'($urandom_range(7));
            for (int i = 0; i < 8; i++) s.comp[i] = pick_attr();
            s.last = ($urandom_range(3) == 0) || (n == 69);
            send_sample(s);
         end
         drain();
      end
      repeat (Latency) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
